// ----- rtl/ksm_pkg.sv -----
// shared constants and types for the scalar kalman speed smoother
`default_nettype none

package ksm_pkg;

  // default parameter values
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  // fixed field widths
  localparam int SAMPLE_W  = 16;
  localparam int RESULT_W  = 32;
  localparam int REG_W     = 24;
  localparam int REG_IDX_W = 1;

  // register indexes
  localparam logic [REG_IDX_W-1:0] CFG_PROC_NOISE = 1'd0;
  localparam logic [REG_IDX_W-1:0] CFG_MEAS_NOISE = 1'd1;

  // reset values
  localparam logic [REG_W-1:0] PROC_NOISE_RST = 24'd655;
  localparam logic [REG_W-1:0] MEAS_NOISE_RST = 24'd65536;
  localparam int               COV_ONE        = 65536;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_COV,
    S_DSTART,
    S_DIV,
    S_MUL,
    S_UPD
  } ksm_state_t;

endpackage

`default_nettype wire

// ----- rtl/ksm_if.sv -----
// request channels of the smoother: sample in, estimate out
`default_nettype none

interface ksm_in_if;
  import ksm_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] speed_sample;

  modport source (output valid, output speed_sample, input ready);
  modport sink (input valid, input speed_sample, output ready);
endinterface

interface ksm_out_if;
  import ksm_pkg::*;
  logic                valid;
  logic                ready;
  logic [RESULT_W-1:0] filtered_speed;

  modport source (output valid, output filtered_speed, input ready);
  modport sink (input valid, input filtered_speed, output ready);
endinterface

`default_nettype wire

// ----- rtl/ksm_div.sv -----
// bit-serial restoring divider for the gain, one quotient bit per cycle
`default_nettype none

module ksm_div #(
  parameter int F     = 16,
  parameter int NUM_W = 24,
  parameter int DEN_W = 25
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [F-1:0]          gain
);
  import ksm_pkg::*;

  localparam int RW   = DEN_W + 1;
  localparam int CNTW = $clog2(F + 2);

  logic [DEN_W-1:0] den_r;
  logic [RW-1:0]    rem_r;
  logic [F:0]       q_r;
  logic             dz_r;
  logic             first_r;
  logic             busy_r;
  logic             done_r;
  logic [CNTW-1:0]  cnt_r;

  logic [RW-1:0] trial;
  logic [RW-1:0] diff;
  logic          ge;

  // first step has no doubling: the numerator is at most the denominator
  assign trial = first_r ? rem_r : {rem_r[RW-2:0], 1'b0};
  assign ge    = trial >= RW'(den_r);
  assign diff  = trial - RW'(den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      first_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        first_r <= 1'b1;
        cnt_r   <= CNTW'(F + 1);
      end else if (busy_r) begin
        first_r <= 1'b0;
        cnt_r   <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= RW'(num);
      dz_r  <= (den == '0);
    end else if (busy_r) begin
      rem_r <= ge ? diff : trial;
      q_r   <= {q_r[F-1:0], ge};
    end
  end

  // quotient of one saturates, zero denominator gives zero
  always_comb begin
    if (dz_r) begin
      gain = '0;
    end else if (q_r[F]) begin
      gain = '1;
    end else begin
      gain = q_r[F-1:0];
    end
  end

  assign done = done_r;

endmodule

`default_nettype wire

// ----- rtl/ksm_mul.sv -----
// bit-serial shift-add multiply by the gain, keeps floor and a sticky bit
`default_nettype none

module ksm_mul #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] mcand,
  input  wire logic [F-1:0] gain,
  output logic              done,
  output logic [W-1:0]      prod,
  output logic              frac_nz
);
  import ksm_pkg::*;

  localparam int CNTW = $clog2(F + 1);

  logic [W-1:0]    mc_r;
  logic [F-1:0]    g_r;
  logic [W-1:0]    acc_r;
  logic            stk_r;
  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;

  logic [W:0] sum;

  assign sum = {1'b0, acc_r} + (g_r[0] ? {1'b0, mc_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(F);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // lsb first: each step adds, then drops one fraction bit into the sticky
  always_ff @(posedge clk) begin
    if (start) begin
      mc_r  <= mcand;
      g_r   <= gain;
      acc_r <= '0;
      stk_r <= 1'b0;
    end else if (busy_r) begin
      acc_r <= sum[W:1];
      stk_r <= stk_r | sum[0];
      g_r   <= g_r >> 1;
    end
  end

  assign done    = done_r;
  assign prod    = acc_r;
  assign frac_nz = stk_r;

endmodule

`default_nettype wire

// ----- rtl/scalar_kalman_speed_smoother.sv -----
// top level of the scalar kalman speed smoother
`default_nettype none

// One-dimensional Kalman filter for a motor speed measurement. Each accepted
// speed_sample (integer rpm, low SAMPLE_BITS bits used) runs one filter cycle:
// the covariance (Q8.F) is raised by process_noise and saturates, the gain
// cov/(cov+measurement_noise) is formed in Q0.F (saturating below one, zero
// when the denominator is zero), the estimate (Q(SAMPLE_BITS).F) moves toward
// the sample by gain times the error, and the covariance is scaled by
// (1-gain); all roundings are floor. filtered_speed is the low 32 bits of the
// new estimate. Each sample passes through S_COV, S_DSTART, S_DIV, S_MUL and
// S_UPD before the next is accepted: a bit-serial restoring divider forms the
// gain, then two bit-serial multipliers form gain times error and gain times
// covariance side by side. One sample is in flight at a time; the result sits
// in an output register so the next sample is taken while it waits. Noise
// registers are to be written by the user through cfg_we/cfg_index/cfg_wdata
// only while the block is idle, which the block itself does not enforce; reset
// loads 655 and 65536, estimate 0 and covariance 1.0.
module scalar_kalman_speed_smoother #(
  parameter int SAMPLE_BITS = ksm_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = ksm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ksm_in_if.sink                             in_ch,
  ksm_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [ksm_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [ksm_pkg::REG_W-1:0]     cfg_wdata
);
  import ksm_pkg::*;

  // widths
  localparam int EW    = SAMPLE_BITS + FRAC_BITS;          // estimate
  localparam int CW    = 8 + FRAC_BITS;                    // covariance
  localparam int DEN_W = ((CW > REG_W) ? CW : REG_W) + 1;  // sums with noise
  localparam int XW    = SAMPLE_W + SAMPLE_BITS;           // sample widening
  localparam int OW    = EW + RESULT_W;                    // result widening

  localparam logic [CW-1:0] COV_MAX = '1;
  // 1.0 in Q8.16; clamps at narrow fractions, same after first saturation
  localparam logic [CW-1:0] COV_RST = (CW > 16) ? CW'(COV_ONE) : COV_MAX;

  ksm_state_t state_r, state_nxt;

  // configuration
  logic [REG_W-1:0] pn_r;
  logic [REG_W-1:0] mn_r;

  // filter state
  logic [EW-1:0] est_r, est_nxt;
  logic [CW-1:0] cov_r, cov_nxt;

  // per-sample working registers
  logic [EW-1:0] target_r, target_nxt;
  logic [CW-1:0] covp_r, covp_nxt;
  logic [EW-1:0] mag_r, mag_nxt;
  logic          up_r, up_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [RESULT_W-1:0] out_data_r, out_data_nxt;

  // serial units
  logic          div_start;
  logic          div_done;
  logic [FRAC_BITS-1:0] gain;
  logic          mul_start;
  logic          mul_e_done;
  logic          mul_c_done;
  logic [EW-1:0] step_e;
  logic          frac_e;
  logic [CW-1:0] step_c;
  logic          frac_c;

  // datapath
  logic [XW-1:0]    samp_ext;
  logic [EW-1:0]    target_in;
  logic [DEN_W-1:0] cov_sum;
  logic [CW-1:0]    cov_sat;
  logic [DEN_W-1:0] den;
  logic [EW-1:0]    est_new;
  logic [CW-1:0]    cov_new;
  logic [OW-1:0]    est_ext;

  // sample bits beyond the field read as zero
  assign samp_ext  = XW'(in_ch.speed_sample);
  assign target_in = {samp_ext[SAMPLE_BITS-1:0], {FRAC_BITS{1'b0}}};

  // predicted covariance, saturating
  assign cov_sum = DEN_W'(cov_r) + DEN_W'(pn_r);
  assign cov_sat = (cov_sum > DEN_W'(COV_MAX)) ? COV_MAX : cov_sum[CW-1:0];

  // gain denominator
  assign den = DEN_W'(covp_r) + DEN_W'(mn_r);

  // moving up uses the floor of the step, moving down its ceiling; neither
  // leaves the range between the old estimate and the sample
  assign est_new = up_r ? (est_r + step_e) : (est_r - (step_e + EW'(frac_e)));
  // floor(cov*(1-gain)) equals cov minus the ceiling of cov*gain
  assign cov_new = covp_r - (step_c + CW'(frac_c));
  assign est_ext = OW'(est_new);

  ksm_div #(
    .F     (FRAC_BITS),
    .NUM_W (CW),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (covp_r),
    .den   (den),
    .done  (div_done),
    .gain  (gain)
  );

  // gain times error
  ksm_mul #(
    .W (EW),
    .F (FRAC_BITS)
  ) u_mul_est (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mag_r),
    .gain    (gain),
    .done    (mul_e_done),
    .prod    (step_e),
    .frac_nz (frac_e)
  );

  // gain times covariance
  ksm_mul #(
    .W (CW),
    .F (FRAC_BITS)
  ) u_mul_cov (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (covp_r),
    .gain    (gain),
    .done    (mul_c_done),
    .prod    (step_c),
    .frac_nz (frac_c)
  );

  // handshake outputs
  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.filtered_speed = out_data_r;

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      est_r       <= '0;
      cov_r       <= COV_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      est_r       <= est_nxt;
      cov_r       <= cov_nxt;
    end
  end

  // noise registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pn_r <= PROC_NOISE_RST;
      mn_r <= MEAS_NOISE_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_PROC_NOISE) begin
        pn_r <= cfg_wdata;
      end
      if (cfg_index == CFG_MEAS_NOISE) begin
        mn_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    target_r   <= target_nxt;
    covp_r     <= covp_nxt;
    mag_r      <= mag_nxt;
    up_r       <= up_nxt;
    out_data_r <= out_data_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    target_nxt    = target_r;
    covp_nxt      = covp_r;
    mag_nxt       = mag_r;
    up_nxt        = up_r;
    est_nxt       = est_r;
    cov_nxt       = cov_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    div_start     = 1'b0;
    mul_start     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          target_nxt = target_in;
          state_nxt  = S_COV;
        end
      end
      S_COV: begin
        // predicted covariance and the size and sign of the error
        covp_nxt  = cov_sat;
        up_nxt    = (target_r >= est_r);
        mag_nxt   = (target_r >= est_r) ? (target_r - est_r) : (est_r - target_r);
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          mul_start = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // both multipliers run the same number of steps
        if (mul_e_done && mul_c_done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        // commit once the output register is free
        if (!out_valid_r || out_ch.ready) begin
          est_nxt       = est_new;
          cov_nxt       = cov_new;
          out_data_nxt  = est_ext[RESULT_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb_scalar_kalman_speed_smoother.sv -----
// self-checking testbench for the scalar kalman speed smoother
`timescale 1ns / 100ps

module tb_scalar_kalman_speed_smoother;
  import ksm_pkg::*;

  // fixed-point layout of the default build
  localparam int          FRAC     = FRAC_BITS_DEF;
  localparam int          SBITS    = SAMPLE_BITS_DEF;
  localparam logic [63:0] UNIT     = 64'd1 << FRAC;
  localparam logic [63:0] GAIN_SAT = UNIT - 64'd1;
  localparam logic [63:0] COV_SAT  = (64'd1 << (8 + FRAC)) - 64'd1;
  localparam logic [63:0] EST_SAT  = (64'd1 << (SBITS + FRAC)) - 64'd1;

  // run control
  localparam int CYCLE_LIMIT = 600000;
  localparam int N_PHASES    = 6;
  localparam int PHASE_ITEMS = 225;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 100;

  // directed table: sample requests and noise writes
  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [REG_IDX_W-1:0]   idx;    // register for ROW_CFG
    logic [REG_W-1:0]       val;    // register value, or sample in the low bits
    logic                   typed;  // expected estimate typed in below
    logic [RESULT_W-1:0]    want;
  } dir_row_t;

  localparam int NDIR = 26;

  dir_row_t dir_rows [NDIR] = '{
    // estimate and sample both zero right after reset
    '{ROW_SAMPLE, CFG_PROC_NOISE, 24'h000000, 1'b1, 32'h0000_0000},
    '{ROW_SAMPLE, CFG_PROC_NOISE, 24'h000000, 1'b1, 32'h0000_0000},
    // full-scale rise, then fall back (negative step rounds the magnitude up)
    '{ROW_SAMPLE, CFG_PROC_NOISE, 24'h00FFFF, 1'b0, 32'h0},
    '{ROW_SAMPLE, CFG_PROC_NOISE, 24'h000000, 1'b0, 32'h0},
    '{ROW_SAMPLE, CFG_PROC_NOISE, 24'h000001, 1'b0, 32'h0},
    '{ROW_SAMPLE, CFG_PROC_NOISE, 24'h00AAAA, 1'b0, 32'h0},
    '{ROW_SAMPLE, CFG_PROC_NOISE, 24'h005555, 1'b0, 32'h0},
    '{ROW_SAMPLE, CFG_PROC_NOISE, 24'h008000, 1'b0, 32'h0},
    // no noise at all: gain pinned just below one, covariance collapses
    // to zero, after which the denominator is zero and the gain is zero
    '{ROW_CFG,    CFG_PROC_NOISE, 24'h000000, 1'b0, 32'h0},
    '{ROW_CFG,    CFG_MEAS_NOISE, 24'h000000, 1'b0, 32'h0},
    '{ROW_SAMPLE, CFG_PROC_NOISE, 24'h000000, 1'b0, 32'h0},
    '{ROW_SAMPLE, CFG_PROC_NOISE, 24'h000000, 1'b0, 32'h0},
    '{ROW_SAMPLE, CFG_PROC_NOISE, 24'h000000, 1'b0, 32'h0},
    '{ROW_SAMPLE, CFG_PROC_NOISE, 24'h00FFFF, 1'b0, 32'h0},
    '{ROW_SAMPLE, CFG_PROC_NOISE, 24'h001234, 1'b0, 32'h0},
    // largest process noise: covariance sum saturates
    '{ROW_CFG,    CFG_PROC_NOISE, 24'hFFFFFF, 1'b0, 32'h0},
    '{ROW_SAMPLE, CFG_PROC_NOISE, 24'h00FFFF, 1'b0, 32'h0},
    '{ROW_SAMPLE, CFG_PROC_NOISE, 24'h00FFFF, 1'b0, 32'h0},
    '{ROW_SAMPLE, CFG_PROC_NOISE, 24'h000000, 1'b0, 32'h0},
    // both noise registers at full scale
    '{ROW_CFG,    CFG_MEAS_NOISE, 24'hFFFFFF, 1'b0, 32'h0},
    '{ROW_SAMPLE, CFG_PROC_NOISE, 24'h000000, 1'b0, 32'h0},
    '{ROW_SAMPLE, CFG_PROC_NOISE, 24'h00FFFF, 1'b0, 32'h0},
    '{ROW_SAMPLE, CFG_PROC_NOISE, 24'h007FFF, 1'b0, 32'h0},
    // back to the reset tuning
    '{ROW_CFG,    CFG_PROC_NOISE, PROC_NOISE_RST, 1'b0, 32'h0},
    '{ROW_CFG,    CFG_MEAS_NOISE, MEAS_NOISE_RST, 1'b0, 32'h0},
    '{ROW_SAMPLE, CFG_PROC_NOISE, 24'h000F0F, 1'b0, 32'h0}
  };

  // sender idle rate per random phase, in percent; the last phase runs flat out
  int idle_rates [N_PHASES] = '{15, 0, 30, 10, 25, 0};

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_wdata;

  ksm_in_if  in_ch ();
  ksm_out_if out_ch ();

  scalar_kalman_speed_smoother dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // filter state and tuning as the testbench tracks them
  logic [31:0]    est_track;
  logic [23:0]    cov_track;
  logic [23:0]    pnoise;
  logic [23:0]    mnoise;

  logic [RESULT_W-1:0] speed_expect_q [$];

  int  n_errors;
  int  samples_sent;
  int  results_seen;
  int  noise_writes;
  int  cycles;
  int  idle_pct;
  bit  quiet;      // no idling on either side
  bit  hold_req;   // asks the receiver for one long hold-off

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // one filter cycle on the tracked state; returns the new estimate
  function automatic logic [31:0] kalman_update(input logic [SAMPLE_W-1:0] smp);
    logic [63:0] target;
    logic [63:0] c;
    logic [63:0] den;
    logic [63:0] gain;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] step;
    logic [63:0] e;
    target = 64'(smp) << FRAC;
    // prior covariance, saturating
    c = 64'(cov_track) + 64'(pnoise);
    if (c > COV_SAT) c = COV_SAT;
    // gain in Q0.F, zero on a zero denominator, held below one
    den = c + 64'(mnoise);
    if (den == 64'd0) begin
      gain = 64'd0;
    end else begin
      gain = (c << FRAC) / den;
      if (gain > GAIN_SAT) gain = GAIN_SAT;
    end
    e = 64'(est_track);
    if (target >= e) begin
      mag  = target - e;
      prod = mag * gain;
      e    = e + (prod >> FRAC);
      if (e > EST_SAT) e = EST_SAT;
    end else begin
      // floor of a negative step: magnitude rounds up on any fraction left
      mag  = e - target;
      prod = mag * gain;
      step = prod >> FRAC;
      if (prod[FRAC-1:0] != '0) step = step + 64'd1;
      e = (step > e) ? 64'd0 : e - step;
    end
    c = (c * (UNIT - gain)) >> FRAC;
    if (c > COV_SAT) c = COV_SAT;
    est_track = e[31:0];
    cov_track = c[23:0];
    return e[31:0];
  endfunction

  // random noise setting, leaning toward the interesting corners
  function automatic logic [REG_W-1:0] pick_noise();
    logic [REG_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      2: v = REG_W'($urandom_range(0, 4095));
      3: v = REG_W'($urandom_range(32768, 262144));
      default: v = REG_W'($urandom);
    endcase
    return v;
  endfunction

  // wait until every request sent so far has produced its estimate
  task automatic wait_all_results();
    while (speed_expect_q.size() != 0) @(posedge clk);
  endtask

  // noise register write, only while the filter is idle
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PROC_NOISE: pnoise = val;
      CFG_MEAS_NOISE: mnoise = val;
      default: ;
    endcase
    noise_writes++;
    @(posedge clk);
  endtask

  // offer one sample request and record its expected estimate on acceptance;
  // valid stays high afterwards so back-to-back requests need no toggle
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic typed,
                             input logic [RESULT_W-1:0] want);
    logic [RESULT_W-1:0] pred;
    in_ch.valid        <= 1'b1;
    in_ch.speed_sample <= smp;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pred = kalman_update(smp);
    speed_expect_q.push_back(typed ? want : pred);
    samples_sent++;
  endtask

  // random sender gap after a request
  task automatic sender_gap();
    if (!quiet && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // result checker: each accepted estimate against the oldest expectation
  always @(posedge clk) begin
    logic [RESULT_W-1:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (speed_expect_q.size() == 0) begin
        $error("filtered_speed: unexpected result %0h", out_ch.filtered_speed);
        n_errors++;
      end else begin
        want = speed_expect_q.pop_front();
        if (out_ch.filtered_speed !== want) begin
          $error("filtered_speed: expected %0h, actual %0h", want, out_ch.filtered_speed);
          n_errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request so the
  // output register stays full and the block stops taking samples
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else if (!quiet && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        stall = $urandom_range(1, 8);
      end else begin
        stall = 0;
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // stimulus
  initial begin
    logic [SAMPLE_W-1:0] smp;
    int track;
    int nz;
    int r;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.speed_sample = '0;
    n_errors           = 0;
    samples_sent       = 0;
    results_seen       = 0;
    noise_writes       = 0;
    cycles             = 0;
    idle_pct           = 10;
    quiet              = 1'b0;
    hold_req           = 1'b0;
    track              = 20000;
    // tracked state after reset
    est_track = '0;
    cov_track = 24'(COV_ONE);
    pnoise    = PROC_NOISE_RST;
    mnoise    = MEAS_NOISE_RST;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        in_ch.valid <= 1'b0;
        wait_all_results();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_sample(dir_rows[i].val[SAMPLE_W-1:0], dir_rows[i].typed, dir_rows[i].want);
        sender_gap();
      end
    end

    // random part: a new tuning per phase, mostly smooth speed profiles
    for (int ph = 0; ph < N_PHASES; ph++) begin
      in_ch.valid <= 1'b0;
      wait_all_results();
      idle_pct = idle_rates[ph];
      quiet    = (ph == N_PHASES - 1);
      write_reg(CFG_PROC_NOISE, pick_noise());
      write_reg(CFG_MEAS_NOISE, pick_noise());
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          smp = SAMPLE_W'($urandom);
        end else if (r < 12) begin
          smp = ($urandom_range(0, 1) != 0) ? '1 : '0;
        end else begin
          // speed track: occasional jump, otherwise slow drift plus noise
          if (r < 16) track = int'($urandom_range(0, 65535));
          else track = track + int'($urandom_range(0, 64)) - 32;
          if (track < 0) track = 0;
          if (track > 65535) track = 65535;
          nz = track + int'($urandom_range(0, 256)) - 128;
          if (nz < 0) nz = 0;
          if (nz > 65535) nz = 65535;
          smp = SAMPLE_W'(nz);
        end
        // long receiver hold-off while requests keep coming
        if (ph == 1 && k == 40) hold_req = 1'b1;
        send_sample(smp, 1'b0, '0);
        if (ph == 3 && k == 110) begin
          // sender pause until the pipe is empty
          in_ch.valid <= 1'b0;
          wait_all_results();
        end else begin
          sender_gap();
        end
      end
    end

    in_ch.valid <= 1'b0;
    wait_all_results();
    repeat (SETTLE) @(posedge clk);

    $display("run covered %0d speed samples and %0d estimates over %0d noise writes,",
             samples_sent, results_seen, noise_writes);
    $display("including zero noise, saturated covariance and long output stalls");
    if (n_errors == 0 && speed_expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- scalar_kalman_speed_smoother.f -----
rtl/ksm_pkg.sv
rtl/ksm_if.sv
rtl/ksm_div.sv
rtl/ksm_mul.sv
rtl/scalar_kalman_speed_smoother.sv
tb/sv/tb_scalar_kalman_speed_smoother.sv
